FILE: design/gf256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^256) arithmetic package
// Shared types, command codes and sequencer states for the field unit.
// ----------------------------------------------------------------------------
package gf256_pkg;

  localparam int unsigned FieldBits = 256;
  localparam int unsigned WordBits  = 64;
  localparam int unsigned InvRounds = 255;
  localparam logic [10:0] PolyLow   = 11'h425;

  typedef logic [FieldBits-1:0] elem_t;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_MUL  = 3'd1,
    CMD_SQR  = 3'd2,
    CMD_INV  = 3'd3,
    CMD_MAC  = 3'd4,
    CMD_LOAD = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_INV_SQ,
    ST_INV_MUL,
    ST_DONE
  } state_t;

  // Control from the sequencer to the multiplier.
  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic done;
  } mul_sts_t;

endpackage

FILE: design/gf256_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^256) multiplier
// Digit-serial carry-less multiply: one 64-bit word of x per cycle against all
// of y, Horner order from the top word, reduced every step.
// ----------------------------------------------------------------------------
module gf256_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  gf256_pkg::mul_ctl_t ctl,
  input  gf256_pkg::elem_t  x,
  input  gf256_pkg::elem_t  y,
  output gf256_pkg::mul_sts_t sts,
  output gf256_pkg::elem_t  prod
);
  import gf256_pkg::*;

  elem_t       acc_r;
  elem_t       x_r;
  elem_t       y_r;
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [FieldBits+WordBits-1:0] wide;
  logic [FieldBits+WordBits-1:0] pp;
  logic [WordBits+10:0]          fold;
  elem_t                         step;
  logic [WordBits-1:0]           dig;

  // acc*x^64 ^ digit*y, then fold the top 64 bits with the low polynomial
  always_comb begin
    dig  = busy_r ? x_r[FieldBits-1 -: WordBits] : x[FieldBits-1 -: WordBits];
    pp   = '0;
    for (int i = 0; i < WordBits; i++) begin
      if (dig[i]) begin
        pp = pp ^ ({{WordBits{1'b0}}, (busy_r ? y_r : y)} << i);
      end
    end
    wide = {(busy_r ? acc_r : elem_t'(0)), {WordBits{1'b0}}} ^ pp;
    fold = '0;
    for (int j = 0; j < 11; j++) begin
      if (PolyLow[j]) begin
        fold = fold ^ ({11'd0, wide[FieldBits+WordBits-1 -: WordBits]} << j);
      end
    end
    step = wide[FieldBits-1:0] ^ elem_t'(fold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r) begin
      acc_r <= step;
      x_r   <= x << WordBits;
      y_r   <= y;
    end else if (busy_r) begin
      acc_r <= step;
      x_r   <= x_r << WordBits;
    end
  end

  assign prod     = acc_r;
  assign sts.done = done_r;

endmodule

FILE: design/gf2_256_field_arith_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^256) field arithmetic unit
// Add, multiply, square, invert, multiply-accumulate and accumulator load.
// ----------------------------------------------------------------------------
// Add, load and unused codes go straight to the result; multiply, square and MAC
// use the digit-serial multiplier; invert runs 255 rounds of square then multiply.
// One item at a time: in_stall is high from accept until the result is taken.
// The shared multiplier serves multiply, square, MAC and both phases of invert.
// Synchronous active-low reset clears the accumulator and the sequencer.
module gf2_256_field_arith_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [63:0] in_a_word0,
  input  logic [63:0] in_a_word1,
  input  logic [63:0] in_a_word2,
  input  logic [63:0] in_a_word3,
  input  logic [63:0] in_b_word0,
  input  logic [63:0] in_b_word1,
  input  logic [63:0] in_b_word2,
  input  logic [63:0] in_b_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_c_word0,
  output logic [63:0] out_c_word1,
  output logic [63:0] out_c_word2,
  output logic [63:0] out_c_word3
);
  import gf256_pkg::*;

  state_t      state_r, state_nxt;
  logic [2:0]  cmd_r;
  elem_t       pw_r;
  elem_t       inv_r;
  elem_t       acc_r;
  elem_t       res_r;
  logic [7:0]  rnd_r;
  logic        start_r;

  elem_t       a_in, b_in, mx, my, prod;
  mul_ctl_t    mctl;
  mul_sts_t    msts;
  logic        in_acc;

  assign a_in   = {in_a_word3, in_a_word2, in_a_word1, in_a_word0};
  assign b_in   = {in_b_word3, in_b_word2, in_b_word1, in_b_word0};
  assign in_acc = in_valid && !in_stall;

  // Operands of the shared multiplier by phase
  always_comb begin
    unique case (state_r)
      ST_INV_SQ:  begin mx = pw_r;  my = pw_r; end
      ST_INV_MUL: begin mx = inv_r; my = pw_r; end
      default:    begin mx = pw_r;  my = inv_r; end
    endcase
  end
  assign mctl.start = start_r;

  gf256_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mctl),
    .x    (mx),
    .y    (my),
    .sts  (msts),
    .prod (prod)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority case (in_command)
            CMD_MUL, CMD_SQR, CMD_MAC: state_nxt = ST_MUL;
            CMD_INV:                  state_nxt = ST_INV_SQ;
            default:                  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL:     if (msts.done) state_nxt = ST_DONE;
      ST_INV_SQ:  if (msts.done) state_nxt = ST_INV_MUL;
      ST_INV_MUL: if (msts.done) state_nxt = (rnd_r == 8'(InvRounds)) ? ST_DONE : ST_INV_SQ;
      ST_DONE:    if (!out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= '0;
      start_r <= 1'b0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      start_r <= 1'b0;
      if (state_r == ST_IDLE && in_acc) begin
        rnd_r <= 8'd1;
        if (in_command != CMD_ADD && in_command != CMD_LOAD && in_command <= CMD_MAC) begin
          start_r <= 1'b1;
        end
        if (in_command == CMD_LOAD) acc_r <= a_in;
      end else if (msts.done) begin
        if (state_r == ST_MUL && cmd_r == CMD_MAC) acc_r <= acc_r ^ prod;
        if (state_r == ST_INV_SQ) start_r <= 1'b1;
        if (state_r == ST_INV_MUL) begin
          rnd_r <= rnd_r + 8'd1;
          if (rnd_r != 8'(InvRounds)) start_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      cmd_r <= in_command;
      pw_r  <= a_in;
      if (in_command == CMD_INV) begin
        inv_r <= elem_t'(1);
      end else begin
        inv_r <= (in_command == CMD_SQR) ? a_in : b_in;
      end
      priority case (in_command)
        CMD_ADD:  res_r <= a_in ^ b_in;
        CMD_LOAD: res_r <= a_in;
        default:  res_r <= '0;
      endcase
    end else if (msts.done) begin
      unique case (state_r)
        ST_MUL:     res_r <= (cmd_r == CMD_MAC) ? (acc_r ^ prod) : prod;
        ST_INV_SQ:  pw_r  <= prod;
        ST_INV_MUL: begin inv_r <= prod; res_r <= prod; end
        default:    res_r <= res_r;
      endcase
    end
  end

  assign out_c_word0 = res_r[63:0];
  assign out_c_word1 = res_r[127:64];
  assign out_c_word2 = res_r[191:128];
  assign out_c_word3 = res_r[255:192];

endmodule

FILE: design/gf256_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^256) unit port checker
// Watches handshakes on the top level ports.
// ----------------------------------------------------------------------------
module gf256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_c_word0
);
  // a beat in is followed by stall on the input
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("no stall after input beat");
  // never a result while input is open
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result while idle");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_c_word0))
    else $error("stalled result moved");
  // after a result beat the unit opens again
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !in_stall) else $error("unit not reopened");
endmodule

bind gf2_256_field_arith_unit_core gf256_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_c_word0(out_c_word0)
);
